### design/thermal_monitor_latched_shutdown_macros.svh
// ----------------------------------------------------------------------------
// Thermal monitor assertion macros
// Shared concurrent assertion forms for the thermal monitor.
// ----------------------------------------------------------------------------
`ifndef THERMAL_MONITOR_LATCHED_SHUTDOWN_MACROS_SVH
`define THERMAL_MONITOR_LATCHED_SHUTDOWN_MACROS_SVH

// same-cycle implication
`define TMLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TMLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tmls_pkg.sv
// ----------------------------------------------------------------------------
// Thermal monitor package
// Fixed widths, constants, codes and control structs of the thermal monitor.
// ----------------------------------------------------------------------------
package tmls_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int TEMP_OUT_W = 17;
    localparam int LEVEL_W    = 17;
    localparam int GAIN_W     = 9;
    localparam int EVENT_W    = 2;
    localparam int REG_IDX_W  = 2;

    localparam int ADC_FULL   = 1023;   // 2**SAMPLE_W - 1
    localparam int FULL_DEG   = 330;    // degrees at full scale
    localparam int START_DEG  = 25;
    localparam int GAIN_MAX   = 256;
    localparam int GAIN_SHIFT = 8;      // gain is in 1/256 units

    localparam logic [LEVEL_W-1:0] WARN_RESET = 17'd15360;
    localparam logic [LEVEL_W-1:0] CRIT_RESET = 17'd17920;
    localparam logic [GAIN_W-1:0]  GAIN_RESET = 9'd51;

    localparam logic [REG_IDX_W-1:0] REG_WARNING  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CRITICAL = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN     = 2'd2;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE         = 2'd0,
        EV_WARNING      = 2'd1,
        EV_SHUTDOWN     = 2'd2,
        EV_MANUAL_RESET = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_RECIP,
        ST_FIX,
        ST_MUL,
        ST_ACC,
        ST_DECIDE
    } seq_state_t;

    typedef struct packed {
        logic load;
        logic scale;
        logic recip;
        logic fix;
        logic mul;
        logic acc;
    } lane_ctrl_t;

    typedef struct packed {
        logic load;
        logic decide;
    } merge_ctrl_t;

endpackage

### design/tmls_if.sv
// ----------------------------------------------------------------------------
// Thermal monitor channels
// Valid/ready channels for sample items and result items.
// ----------------------------------------------------------------------------
interface tmls_in_if;
    import tmls_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] servo_sample;
    logic [SAMPLE_W-1:0] battery_sample;
    logic [SAMPLE_W-1:0] buck_sample;
    logic                reset_pressed;

    modport source (
        output valid, servo_sample, battery_sample, buck_sample, reset_pressed,
        input  ready
    );
    modport sink (
        input  valid, servo_sample, battery_sample, buck_sample, reset_pressed,
        output ready
    );
endinterface

interface tmls_out_if;
    import tmls_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [TEMP_OUT_W-1:0] servo_temp;
    logic [TEMP_OUT_W-1:0] battery_temp;
    logic [TEMP_OUT_W-1:0] buck_temp;
    logic [EVENT_W-1:0]    event_code;
    logic                  shutdown_latched;
    logic                  servo_enable;

    modport source (
        output valid, servo_temp, battery_temp, buck_temp, event_code,
               shutdown_latched, servo_enable,
        input  ready
    );
    modport sink (
        input  valid, servo_temp, battery_temp, buck_temp, event_code,
               shutdown_latched, servo_enable,
        output ready
    );
endinterface

### design/tmls_lane.sv
// ----------------------------------------------------------------------------
// Thermal monitor filter lane
// ADC code to Q.FRAC_BITS degrees by reciprocal multiply, then one step of
// the exponential filter. One stage per sequencer step.
// ----------------------------------------------------------------------------
module tmls_lane #(
    parameter int FRAC_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tmls_pkg::lane_ctrl_t           ctrl,
    input  logic [tmls_pkg::SAMPLE_W-1:0]  raw,
    input  logic [tmls_pkg::GAIN_W-1:0]    gain,
    output logic [FRAC_BITS+8:0]           filt
);
    import tmls_pkg::*;

    localparam int TW = FRAC_BITS + 9;          // holds 330 << FRAC_BITS
    localparam int XW = TW + SAMPLE_W;          // raw * full scale
    localparam int MW = XW - 9;                 // reciprocal width
    localparam int PW = XW + MW;
    localparam int RW = SAMPLE_W + 1;           // remainder < 2 * 1023
    localparam int GW = GAIN_W + TW;

    localparam logic [TW-1:0] FULL_SCALE = TW'(FULL_DEG << FRAC_BITS);
    localparam logic [TW-1:0] START_TEMP = TW'(START_DEG << FRAC_BITS);
    localparam longint unsigned RECIP_L  = (64'd1 << XW) / 64'(ADC_FULL);
    localparam logic [MW-1:0] RECIP      = MW'(RECIP_L);

    logic [SAMPLE_W-1:0] raw_reg;
    logic [XW-1:0]       x_reg, x_next;
    logic [TW-1:0]       q0_reg, q0_next;
    logic [TW-1:0]       t_reg, t_next;
    logic [GW-1:0]       prod_reg, prod_next;
    logic                ge_reg, ge_next;
    logic [TW-1:0]       f_reg, f_next;

    logic [PW-1:0] recip_prod;
    logic [XW-1:0] q_times;
    logic [RW-1:0] rem;
    logic [TW-1:0] mag;
    logic [GW-1:0] prod_rnd;

    always_comb
    begin
        x_next     = XW'(raw_reg) * XW'(FULL_SCALE);
        recip_prod = PW'(x_reg) * PW'(RECIP);
        q0_next    = recip_prod[XW +: TW];

        // q0 is low by at most one: fix from the remainder x - q0*1023
        q_times = (XW'(q0_reg) << SAMPLE_W) - XW'(q0_reg);
        rem     = x_reg[RW-1:0] - q_times[RW-1:0];
        t_next  = q0_reg + TW'(rem >= RW'(ADC_FULL));

        ge_next   = (t_reg >= f_reg);
        mag       = ge_next ? (t_reg - f_reg) : (f_reg - t_reg);
        prod_next = GW'(gain) * GW'(mag);

        // falling: round the step magnitude up, i.e. floor of a negative value
        prod_rnd = prod_reg + GW'((1 << GAIN_SHIFT) - 1);
        if (ge_reg)
        begin
            f_next = f_reg + prod_reg[GAIN_SHIFT +: TW];
        end
        else
        begin
            f_next = f_reg - prod_rnd[GAIN_SHIFT +: TW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            raw_reg <= raw;
        end
        if (ctrl.scale)
        begin
            x_reg <= x_next;
        end
        if (ctrl.recip)
        begin
            q0_reg <= q0_next;
        end
        if (ctrl.fix)
        begin
            t_reg <= t_next;
        end
        if (ctrl.mul)
        begin
            prod_reg <= prod_next;
            ge_reg   <= ge_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_reg <= START_TEMP;
        end
        else if (ctrl.acc)
        begin
            f_reg <= f_next;
        end
    end

    assign filt = f_reg;

endmodule

### design/tmls_merge.sv
// ----------------------------------------------------------------------------
// Thermal monitor merge stage
// Maximum of the three filtered lanes, threshold checks, shutdown latch and
// the result register.
// ----------------------------------------------------------------------------
module tmls_merge #(
    parameter int FRAC_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tmls_pkg::merge_ctrl_t            ctrl,
    input  logic                             button,
    input  logic [tmls_pkg::LEVEL_W-1:0]     warn_level,
    input  logic [tmls_pkg::LEVEL_W-1:0]     crit_level,
    input  logic [FRAC_BITS+8:0]             servo_filt,
    input  logic [FRAC_BITS+8:0]             battery_filt,
    input  logic [FRAC_BITS+8:0]             buck_filt,
    output logic [tmls_pkg::TEMP_OUT_W-1:0]  servo_temp,
    output logic [tmls_pkg::TEMP_OUT_W-1:0]  battery_temp,
    output logic [tmls_pkg::TEMP_OUT_W-1:0]  buck_temp,
    output tmls_pkg::event_t                 event_code,
    output logic                             latched,
    output logic                             enabled
);
    import tmls_pkg::*;

    localparam int TW = FRAC_BITS + 9;
    localparam int CW = TW + LEVEL_W;          // common compare width
    localparam int EW = TW + TEMP_OUT_W;

    logic button_reg;
    logic latch_reg, latch_next;
    logic enable_reg, enable_next;
    event_t event_reg, event_next;
    logic [TEMP_OUT_W-1:0] servo_reg, battery_reg, buck_reg;

    logic [TW-1:0] max_sb, max_all;
    logic [CW-1:0] max_ext;
    logic [EW-1:0] servo_ext, battery_ext, buck_ext;

    always_comb
    begin
        max_sb  = (battery_filt > servo_filt) ? battery_filt : servo_filt;
        max_all = (buck_filt > max_sb) ? buck_filt : max_sb;
        max_ext = CW'(max_all);

        latch_next  = latch_reg;
        enable_next = enable_reg;
        event_next  = EV_NONE;
        if (latch_reg)
        begin
            if (button_reg)
            begin
                latch_next  = 1'b0;
                enable_next = 1'b1;
                event_next  = EV_MANUAL_RESET;
            end
        end
        else if (max_ext >= CW'(crit_level))
        begin
            latch_next  = 1'b1;
            enable_next = 1'b0;
            event_next  = EV_SHUTDOWN;
        end
        else if (max_ext >= CW'(warn_level))
        begin
            event_next = EV_WARNING;
        end

        servo_ext   = EW'(servo_filt);
        battery_ext = EW'(battery_filt);
        buck_ext    = EW'(buck_filt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg  <= 1'b0;
            enable_reg <= 1'b0;
        end
        else if (ctrl.decide)
        begin
            latch_reg  <= latch_next;
            enable_reg <= enable_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            button_reg <= button;
        end
        if (ctrl.decide)
        begin
            event_reg   <= event_next;
            servo_reg   <= servo_ext[TEMP_OUT_W-1:0];
            battery_reg <= battery_ext[TEMP_OUT_W-1:0];
            buck_reg    <= buck_ext[TEMP_OUT_W-1:0];
        end
    end

    assign servo_temp   = servo_reg;
    assign battery_temp = battery_reg;
    assign buck_temp    = buck_reg;
    assign event_code   = event_reg;
    assign latched      = latch_reg;
    assign enabled      = enable_reg;

endmodule

### design/thermal_monitor_latched_shutdown.sv
// ----------------------------------------------------------------------------
// Thermal monitor with latched over-temperature shutdown
// Three filtered temperature lanes, a merge stage with the shutdown latch,
// and a sequencer that steps one sample item through them.
// ----------------------------------------------------------------------------
//  channel     role    contents
//  sample_ch   sink    three ADC codes, reset button level
//  result_ch   source  three filtered temperatures, event, latch, enable
//  wr_*        write   warning level, critical level, filter gain
//
//  An item passes through the accept edge, then scale, reciprocal multiply,
//  remainder fix, gain multiply, filter update and decide, in that order.
//  The sequencer holds one item at a time; the next is taken the cycle
//  after its predecessor reaches the result register.
//  A stalled result waits in the result register; the decide step holds
//  until it is taken. Reset puts all filters at 25 degrees, servos disabled.
// ----------------------------------------------------------------------------
`include "thermal_monitor_latched_shutdown_macros.svh"

module thermal_monitor_latched_shutdown #(
    parameter int FRAC_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tmls_in_if.sink                          sample_ch,
    tmls_out_if.source                       result_ch,
    input  logic                             wr_en,
    input  logic [tmls_pkg::REG_IDX_W-1:0]   wr_index,
    input  logic [tmls_pkg::LEVEL_W-1:0]     wr_data
);
    import tmls_pkg::*;

    localparam int TW = FRAC_BITS + 9;

    seq_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0] warn_reg, crit_reg;
    logic [GAIN_W-1:0]  gain_reg, gain_eff;

    lane_ctrl_t  lane_ctrl;
    merge_ctrl_t merge_ctrl;
    logic accept, fire;

    logic [TW-1:0] servo_filt, battery_filt, buck_filt;
    event_t event_out;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_reg <= WARN_RESET;
            crit_reg <= CRIT_RESET;
            gain_reg <= GAIN_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_WARNING:  warn_reg <= wr_data;
                REG_CRITICAL: crit_reg <= wr_data;
                REG_GAIN:     gain_reg <= wr_data[GAIN_W-1:0];
                default:      ;
            endcase
        end
    end

    assign gain_eff = (gain_reg > GAIN_W'(GAIN_MAX)) ? GAIN_W'(GAIN_MAX) : gain_reg;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        lane_ctrl  = '0;
        merge_ctrl = '0;
        accept     = 1'b0;
        fire       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                accept = sample_ch.valid;
                if (sample_ch.valid)
                begin
                    lane_ctrl.load  = 1'b1;
                    merge_ctrl.load = 1'b1;
                    state_next      = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                lane_ctrl.scale = 1'b1;
                state_next      = ST_RECIP;
            end
            ST_RECIP:
            begin
                lane_ctrl.recip = 1'b1;
                state_next      = ST_FIX;
            end
            ST_FIX:
            begin
                lane_ctrl.fix = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                lane_ctrl.mul = 1'b1;
                state_next    = ST_ACC;
            end
            ST_ACC:
            begin
                lane_ctrl.acc = 1'b1;
                state_next    = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!out_valid_reg || result_ch.ready)
                begin
                    fire              = 1'b1;
                    merge_ctrl.decide = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = fire || (out_valid_reg && !result_ch.ready);
    end

    assign sample_ch.ready = (state_reg == ST_IDLE);

    tmls_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_servo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (lane_ctrl),
        .raw   (sample_ch.servo_sample),
        .gain  (gain_eff),
        .filt  (servo_filt)
    );

    tmls_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_battery (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (lane_ctrl),
        .raw   (sample_ch.battery_sample),
        .gain  (gain_eff),
        .filt  (battery_filt)
    );

    tmls_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_buck (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (lane_ctrl),
        .raw   (sample_ch.buck_sample),
        .gain  (gain_eff),
        .filt  (buck_filt)
    );

    tmls_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (merge_ctrl),
        .button       (sample_ch.reset_pressed),
        .warn_level   (warn_reg),
        .crit_level   (crit_reg),
        .servo_filt   (servo_filt),
        .battery_filt (battery_filt),
        .buck_filt    (buck_filt),
        .servo_temp   (result_ch.servo_temp),
        .battery_temp (result_ch.battery_temp),
        .buck_temp    (result_ch.buck_temp),
        .event_code   (event_out),
        .latched      (result_ch.shutdown_latched),
        .enabled      (result_ch.servo_enable)
    );

    assign result_ch.event_code = event_out;
    assign result_ch.valid      = out_valid_reg;

    // checks
    `TMLS_ASSERT_NOW(a_latch_disables, result_ch.valid, !(result_ch.shutdown_latched && result_ch.servo_enable), "servos enabled while shutdown latched")
    `TMLS_ASSERT_NOW(a_shutdown_latches, result_ch.valid && (event_out == EV_SHUTDOWN), result_ch.shutdown_latched, "shutdown event without latch")
    `TMLS_ASSERT_NOW(a_manual_enables, result_ch.valid && (event_out == EV_MANUAL_RESET), result_ch.servo_enable && !result_ch.shutdown_latched, "manual reset left latch set")
    `TMLS_ASSERT_NEXT(a_one_in_flight, accept, !sample_ch.ready && !fire, "second item taken while one in flight")

endmodule

### dv/thermal_monitor_latched_shutdown_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal monitor testbench
// Sends sample items with random gaps and stalls the result side at random.
// Every result is checked field by field against a predictor of the three
// filters, the hottest-channel decision and the shutdown latch, or against the
// written result of a typed row. A short table of directed items runs first,
// then several phases of random items, each under its own register settings.
// ----------------------------------------------------------------------------
module thermal_monitor_latched_shutdown_tb;
    import tmls_pkg::*;

    localparam int FRAC_BITS   = 8;
    localparam int TEMP_TOP    = FULL_DEG << FRAC_BITS;     // 330 degrees
    localparam int ROUND_UP    = (1 << GAIN_SHIFT) - 1;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 140;
    localparam int TAIL_CYCLES = 20;

    // index with no register behind it; writes must be dropped
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] servo;
        logic [SAMPLE_W-1:0] battery;
        logic [SAMPLE_W-1:0] buck;
        logic                pressed;
    } sample_item_t;

    typedef struct packed {
        logic [TEMP_OUT_W-1:0] servo_temp;
        logic [TEMP_OUT_W-1:0] battery_temp;
        logic [TEMP_OUT_W-1:0] buck_temp;
        event_t                event_code;
        logic                  shutdown_latched;
        logic                  servo_enable;
    } thermal_result_t;

    typedef struct packed {
        logic               set_levels;
        logic [LEVEL_W-1:0] warn;
        logic [LEVEL_W-1:0] crit;
        logic [LEVEL_W-1:0] gain_word;
        sample_item_t       item;
        logic               typed;
        thermal_result_t    want;
    } script_row_t;

    localparam thermal_result_t PREDICTED = '0;
    localparam logic [LEVEL_W-1:0] LVL_MAX = 17'h1FFFF;

    // set, warn, crit, gain word | servo, battery, buck, button | typed, result
    localparam script_row_t SCRIPT [0:21] = '{
        // reset settings
        '{1'b0, 17'd0, 17'd0, 17'd0, '{10'd0, 10'd0, 10'd0, 1'b0}, 1'b0, PREDICTED},
        '{1'b0, 17'd0, 17'd0, 17'd0, '{10'd1023, 10'd1023, 10'd1023, 1'b1}, 1'b0, PREDICTED},
        '{1'b0, 17'd0, 17'd0, 17'd0, '{10'd1023, 10'd1023, 10'd1023, 1'b0}, 1'b0, PREDICTED},
        '{1'b0, 17'd0, 17'd0, 17'd0, '{10'd512, 10'd256, 10'd128, 1'b0}, 1'b0, PREDICTED},
        '{1'b0, 17'd0, 17'd0, 17'd0, '{10'd0, 10'd0, 10'd0, 1'b1}, 1'b0, PREDICTED},
        // full gain: filters follow the samples
        '{1'b1, WARN_RESET, CRIT_RESET, 17'd256, '{10'd0, 10'd0, 10'd0, 1'b0},
          1'b1, '{17'd0, 17'd0, 17'd0, EV_NONE, 1'b0, 1'b1}},
        '{1'b0, 17'd0, 17'd0, 17'd0, '{10'd1023, 10'd0, 10'd0, 1'b0},
          1'b1, '{17'd84480, 17'd0, 17'd0, EV_SHUTDOWN, 1'b1, 1'b0}},
        '{1'b0, 17'd0, 17'd0, 17'd0, '{10'd0, 10'd1023, 10'd1023, 1'b0},
          1'b1, '{17'd0, 17'd84480, 17'd84480, EV_NONE, 1'b1, 1'b0}},
        '{1'b0, 17'd0, 17'd0, 17'd0, '{10'd0, 10'd0, 10'd0, 1'b1},
          1'b1, '{17'd0, 17'd0, 17'd0, EV_MANUAL_RESET, 1'b0, 1'b1}},
        '{1'b0, 17'd0, 17'd0, 17'd0, '{10'd0, 10'd0, 10'd1023, 1'b1},
          1'b1, '{17'd0, 17'd0, 17'd84480, EV_SHUTDOWN, 1'b1, 1'b0}},
        '{1'b0, 17'd0, 17'd0, 17'd0, '{10'd0, 10'd0, 10'd0, 1'b1},
          1'b1, '{17'd0, 17'd0, 17'd0, EV_MANUAL_RESET, 1'b0, 1'b1}},
        // just under warning, exactly warning, exactly critical
        '{1'b0, 17'd0, 17'd0, 17'd0, '{10'd185, 10'd0, 10'd0, 1'b0}, 1'b0, PREDICTED},
        '{1'b0, 17'd0, 17'd0, 17'd0, '{10'd186, 10'd0, 10'd0, 1'b0}, 1'b0, PREDICTED},
        '{1'b0, 17'd0, 17'd0, 17'd0, '{10'd0, 10'd217, 10'd0, 1'b0}, 1'b0, PREDICTED},
        '{1'b0, 17'd0, 17'd0, 17'd0, '{10'd0, 10'd0, 10'd0, 1'b1}, 1'b0, PREDICTED},
        // zero gain holds the filters
        '{1'b1, WARN_RESET, CRIT_RESET, 17'd0, '{10'd1023, 10'd1023, 10'd1023, 1'b0},
          1'b1, '{17'd0, 17'd0, 17'd0, EV_NONE, 1'b0, 1'b1}},
        // 511 behaves as 256
        '{1'b1, WARN_RESET, CRIT_RESET, LVL_MAX, '{10'd1023, 10'd512, 10'd0, 1'b0},
          1'b0, PREDICTED},
        // zero thresholds; gain word with bits above the register width
        '{1'b1, 17'd0, 17'd0, 17'h10080, '{10'd0, 10'd0, 10'd0, 1'b1}, 1'b0, PREDICTED},
        '{1'b0, 17'd0, 17'd0, 17'd0, '{10'd0, 10'd0, 10'd0, 1'b0}, 1'b0, PREDICTED},
        // thresholds out of reach, slowest gain
        '{1'b1, LVL_MAX, LVL_MAX, 17'd1, '{10'd1023, 10'd1023, 10'd1023, 1'b1},
          1'b0, PREDICTED},
        '{1'b0, 17'd0, 17'd0, 17'd0, '{10'd1023, 10'd1023, 10'd1023, 1'b0},
          1'b0, PREDICTED},
        '{1'b1, 17'd0, LVL_MAX, 17'd256, '{10'd0, 10'd0, 10'd0, 1'b0},
          1'b1, '{17'd0, 17'd0, 17'd0, EV_WARNING, 1'b0, 1'b1}}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               wr_en;
    logic [REG_IDX_W-1:0] wr_index;
    logic [LEVEL_W-1:0] wr_data;

    tmls_in_if  sample_ch ();
    tmls_out_if result_ch ();

    thermal_monitor_latched_shutdown i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    // predictor state
    logic [LEVEL_W-1:0]    warn_level_q;
    logic [LEVEL_W-1:0]    crit_level_q;
    logic [GAIN_W-1:0]     gain_q;
    logic [TEMP_OUT_W-1:0] servo_f;
    logic [TEMP_OUT_W-1:0] battery_f;
    logic [TEMP_OUT_W-1:0] buck_f;
    logic                  latched_q;
    logic                  enabled_q;

    thermal_result_t expected_results [$];
    int unsigned     mismatches = 0;
    logic            steady_run = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [TEMP_OUT_W-1:0] adc_to_celsius(input logic [SAMPLE_W-1:0] raw);
        longint unsigned scaled;
        scaled = longint'(raw) * TEMP_TOP / ADC_FULL;
        return TEMP_OUT_W'(scaled);
    endfunction

    // floor of gain*(cur-prev)/256 in both directions
    function automatic logic [TEMP_OUT_W-1:0] ema_update(input logic [TEMP_OUT_W-1:0] prev,
                                                         input logic [TEMP_OUT_W-1:0] cur);
        longint unsigned g;
        longint unsigned delta;
        g = (gain_q > GAIN_W'(GAIN_MAX)) ? 64'(GAIN_MAX) : 64'(gain_q);
        if (cur >= prev)
        begin
            delta = (g * (cur - prev)) >> GAIN_SHIFT;
            return TEMP_OUT_W'(prev + delta);
        end
        delta = (g * (prev - cur) + ROUND_UP) >> GAIN_SHIFT;
        return TEMP_OUT_W'(prev - delta);
    endfunction

    function automatic thermal_result_t advance_monitor(input sample_item_t item);
        thermal_result_t       r;
        logic [TEMP_OUT_W-1:0] hottest;
        servo_f   = ema_update(servo_f, adc_to_celsius(item.servo));
        battery_f = ema_update(battery_f, adc_to_celsius(item.battery));
        buck_f    = ema_update(buck_f, adc_to_celsius(item.buck));
        hottest = servo_f;
        if (battery_f > hottest)
            hottest = battery_f;
        if (buck_f > hottest)
            hottest = buck_f;
        r.event_code = EV_NONE;
        if (latched_q)
        begin
            if (item.pressed)
            begin
                latched_q    = 1'b0;
                enabled_q    = 1'b1;
                r.event_code = EV_MANUAL_RESET;
            end
        end
        else if (hottest >= crit_level_q)
        begin
            latched_q    = 1'b1;
            enabled_q    = 1'b0;
            r.event_code = EV_SHUTDOWN;
        end
        else if (hottest >= warn_level_q)
            r.event_code = EV_WARNING;
        r.servo_temp       = servo_f;
        r.battery_temp     = battery_f;
        r.buck_temp        = buck_f;
        r.shutdown_latched = latched_q;
        r.servo_enable     = enabled_q;
        return r;
    endfunction

    // mostly short, now and then long
    function automatic int unsigned gap_length();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 3);
        return $urandom_range(8, 48);
    endfunction

    function automatic logic [SAMPLE_W-1:0] draw_sample(input int unsigned climate);
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        case (climate)
            0:       return SAMPLE_W'($urandom_range(0, 150));
            1:       return SAMPLE_W'($urandom_range(150, 260));
            2:       return SAMPLE_W'($urandom_range(200, ADC_FULL));
            default: return SAMPLE_W'($urandom_range(0, ADC_FULL));
        endcase
    endfunction

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        case (idx)
            REG_WARNING:  warn_level_q = data;
            REG_CRITICAL: crit_level_q = data;
            REG_GAIN:     gain_q       = data[GAIN_W-1:0];
            default:      ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [LEVEL_W-1:0] warn, input logic [LEVEL_W-1:0] crit,
                                  input logic [LEVEL_W-1:0] gain_word);
        write_reg(REG_WARNING, warn);
        write_reg(REG_CRITICAL, crit);
        write_reg(REG_GAIN, gain_word);
        write_reg(REG_SPARE, LEVEL_W'($urandom));
        wr_en <= 1'b0;
    endtask

    // drop valid and wait for every outstanding result
    task automatic quiesce();
        sample_ch.valid <= 1'b0;
        @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    // entered and left at a falling edge
    task automatic send_sample(input sample_item_t item, input logic typed,
                               input thermal_result_t want);
        int unsigned     gap;
        thermal_result_t forecast;
        gap = (steady_run || $urandom_range(0, 2) != 0) ? 0 : gap_length();
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.servo_sample   <= item.servo;
        sample_ch.battery_sample <= item.battery;
        sample_ch.buck_sample    <= item.buck;
        sample_ch.reset_pressed  <= item.pressed;
        sample_ch.valid          <= 1'b1;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        forecast = advance_monitor(item);
        expected_results.push_back(typed ? want : forecast);
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [TEMP_OUT_W-1:0] want,
                               input logic [TEMP_OUT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin : stimulus
        sample_item_t       item;
        logic [LEVEL_W-1:0] warn;
        logic [LEVEL_W-1:0] crit;
        logic [LEVEL_W-1:0] gain_word;
        int unsigned        climate;

        rst_n                    = 1'b0;
        wr_en                    = 1'b0;
        wr_index                 = '0;
        wr_data                  = '0;
        sample_ch.valid          = 1'b0;
        sample_ch.servo_sample   = '0;
        sample_ch.battery_sample = '0;
        sample_ch.buck_sample    = '0;
        sample_ch.reset_pressed  = 1'b0;

        warn_level_q = WARN_RESET;
        crit_level_q = CRIT_RESET;
        gain_q       = GAIN_RESET;
        servo_f      = TEMP_OUT_W'(START_DEG << FRAC_BITS);
        battery_f    = TEMP_OUT_W'(START_DEG << FRAC_BITS);
        buck_f       = TEMP_OUT_W'(START_DEG << FRAC_BITS);
        latched_q    = 1'b0;
        enabled_q    = 1'b0;
        climate      = 3;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (SCRIPT[r])
        begin
            if (SCRIPT[r].set_levels)
            begin
                quiesce();
                apply_settings(SCRIPT[r].warn, SCRIPT[r].crit, SCRIPT[r].gain_word);
            end
            send_sample(SCRIPT[r].item, SCRIPT[r].typed, SCRIPT[r].want);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            quiesce();
            case (phase)
                0:
                begin
                    warn      = WARN_RESET;
                    crit      = CRIT_RESET;
                    gain_word = LEVEL_W'(GAIN_RESET);
                end
                1:
                begin
                    warn      = LEVEL_W'($urandom_range(8000, 40000));
                    crit      = LEVEL_W'(warn + $urandom_range(0, 20000));
                    gain_word = LEVEL_W'(GAIN_MAX);
                end
                2:
                begin
                    warn      = LEVEL_W'($urandom_range(0, 20000));
                    crit      = LEVEL_W'(warn + $urandom_range(500, 6000));
                    gain_word = LEVEL_W'(1);
                end
                3:
                begin
                    warn      = LEVEL_W'($urandom);
                    crit      = LEVEL_W'($urandom);
                    gain_word = LEVEL_W'($urandom);
                end
                4:
                begin
                    // either order, gain may be zero or over full scale
                    warn      = LEVEL_W'($urandom_range(0, TEMP_TOP));
                    crit      = LEVEL_W'($urandom_range(0, TEMP_TOP));
                    gain_word = LEVEL_W'($urandom_range(0, 511));
                end
                default:
                begin
                    warn      = LEVEL_W'($urandom_range(10000, 30000));
                    crit      = LEVEL_W'(warn + $urandom_range(1000, 8000));
                    gain_word = LEVEL_W'($urandom_range(1, GAIN_MAX));
                end
            endcase
            apply_settings(warn, crit, gain_word);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 20 == 0)
                    climate = $urandom_range(0, 3);
                if (n % 35 == 0)
                    steady_run <= ($urandom_range(0, 3) == 0);
                item.servo   = draw_sample(climate);
                item.battery = draw_sample(climate);
                item.buck    = draw_sample(climate);
                item.pressed = ($urandom_range(0, 5) == 0);
                send_sample(item, 1'b0, PREDICTED);
            end
        end

        quiesce();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // result side back-pressure
    initial
    begin : ready_driver
        int unsigned stall_left;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (steady_run)
                result_ch.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = gap_length();
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        thermal_result_t want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result item with none outstanding");
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("servo_temp", want.servo_temp, result_ch.servo_temp);
                check_field("battery_temp", want.battery_temp, result_ch.battery_temp);
                check_field("buck_temp", want.buck_temp, result_ch.buck_temp);
                check_field("event_code", TEMP_OUT_W'(want.event_code),
                            TEMP_OUT_W'(result_ch.event_code));
                check_field("shutdown_latched", TEMP_OUT_W'(want.shutdown_latched),
                            TEMP_OUT_W'(result_ch.shutdown_latched));
                check_field("servo_enable", TEMP_OUT_W'(want.servo_enable),
                            TEMP_OUT_W'(result_ch.servo_enable));
            end
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/tmls_pkg.sv
design/tmls_if.sv
design/tmls_lane.sv
design/tmls_merge.sv
design/thermal_monitor_latched_shutdown.sv
dv/thermal_monitor_latched_shutdown_tb.sv
